// File: src/tlrf_pkg.sv
// Shared types and constants of the terminated line receive framer.
package tlrf_pkg;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  // Reasons for a reception restart.
  typedef enum logic [1:0] {
    CAUSE_NONE       = 2'd0,
    CAUSE_BAD_SECOND = 2'd1,
    CAUSE_OVERFLOW   = 2'd2
  } cause_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_FIRST_TERM  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_TERM = 2'd1;

  // Terminator values after reset.
  localparam logic [7:0] FIRST_TERM_RST  = 8'h61;
  localparam logic [7:0] SECOND_TERM_RST = 8'h62;

endpackage

// File: src/tlrf_if.sv
// Request and result channel interfaces of the terminated line receive framer.
interface tlrf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output cmd, output rx_byte, output read_index, input ready);
  modport sink (input valid, input cmd, input rx_byte, input read_index, output ready);
endinterface

interface tlrf_rsp_if;
  logic       valid;
  logic       ready;
  logic       line_done;
  logic       first_seen;
  logic [7:0] line_length;
  logic [7:0] read_data;
  logic [1:0] restart_cause;

  modport source (output valid, output line_done, output first_seen, output line_length,
                  output read_data, output restart_cause, input ready);
  modport sink (input valid, input line_done, input first_seen, input line_length,
                input read_data, input restart_cause, output ready);
endinterface

// File: src/tlrf_store.sv
// Line store memory with a fill mark that makes never-written entries read as zero.
module tlrf_store #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          hit_q;
  logic          hit_d;
  logic [AW:0]   fill_q;
  logic [AW:0]   fill_d;

  // Writes always land at or below the fill mark, so written entries form a prefix.
  always_comb begin
    fill_d = fill_q;
    if (we_i && ({1'b0, waddr_i} == fill_q)) begin
      fill_d = fill_q + 1'b1;
    end
    hit_d = hit_q;
    if (re_i) begin
      hit_d = ({1'b0, raddr_i} < fill_q);
    end
  end

  // Memory array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Fill mark and read hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      hit_q  <= hit_d;
    end
  end

  assign rdata_o = hit_q ? rdata_q : 8'd0;

endmodule

// File: src/terminated_line_receive_framer.sv
// Top level of the terminated line receive framer.
// Each request (received byte, store read or line release) has its result in the output
// register on the cycle after it is accepted; one request per cycle is sustained while the
// receiver takes results, set by the status update and the one registered read port of the
// line store. A new request is taken whenever the output register is empty or is being emptied
// in the same cycle. The line store needs no clearing pass after reset: a fill mark tracks the
// written prefix and entries above it read as zero. The user must write terminators on the
// configuration port only while no request is in flight; the block does not enforce this.
module terminated_line_receive_framer #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_wdata_i,
  tlrf_req_if.sink                    in_i,
  tlrf_rsp_if.source                  out_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned IW = (AW + 1 > 8) ? AW + 1 : 8;

  logic [7:0]    first_term_q;
  logic [7:0]    second_term_q;
  logic          done_q, done_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] count_q, count_d;
  logic [1:0]    cause_q, cause_d;
  logic          out_valid_q;
  logic          rd_ok_q;
  logic          accept;
  logic          store_we;
  logic          store_re;
  logic [7:0]    store_rdata;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Status update for one request.
  always_comb begin
    done_d   = done_q;
    pend_d   = pend_q;
    count_d  = count_q;
    cause_d  = tlrf_pkg::CAUSE_NONE;
    store_we = 1'b0;
    store_re = 1'b0;
    case (in_i.cmd)
      tlrf_pkg::CMD_RX: begin
        if (done_q) begin
          // A held line ignores further bytes.
        end else if (pend_q) begin
          if (in_i.rx_byte != second_term_q) begin
            pend_d  = 1'b0;
            count_d = '0;
            cause_d = tlrf_pkg::CAUSE_BAD_SECOND;
          end else begin
            done_d = 1'b1;
          end
        end else if (in_i.rx_byte == first_term_q) begin
          pend_d = 1'b1;
        end else begin
          store_we = 1'b1;
          if (count_q == AW'(BUFFER_DEPTH - 1)) begin
            count_d = '0;
            cause_d = tlrf_pkg::CAUSE_OVERFLOW;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      tlrf_pkg::CMD_READ: begin
        store_re = (IW'(in_i.read_index) < IW'(BUFFER_DEPTH));
      end
      tlrf_pkg::CMD_RELEASE: begin
        done_d  = 1'b0;
        pend_d  = 1'b0;
        count_d = '0;
      end
      default: begin
        // Unused command leaves the status as it is.
      end
    endcase
  end

  // Only in-range read requests use the store read port; every other request answers zero.
  tlrf_store #(
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept && store_we),
    .waddr_i (count_q),
    .wdata_i (in_i.rx_byte),
    .re_i    (accept && store_re),
    .raddr_i (AW'(in_i.read_index)),
    .rdata_o (store_rdata)
  );

  // Status, result register and terminators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q        <= 1'b0;
      pend_q        <= 1'b0;
      count_q       <= '0;
      cause_q       <= tlrf_pkg::CAUSE_NONE;
      rd_ok_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      first_term_q  <= tlrf_pkg::FIRST_TERM_RST;
      second_term_q <= tlrf_pkg::SECOND_TERM_RST;
    end else begin
      if (accept) begin
        done_q  <= done_d;
        pend_q  <= pend_d;
        count_q <= count_d;
        cause_q <= cause_d;
        rd_ok_q <= store_re;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          tlrf_pkg::REG_FIRST_TERM:  first_term_q  <= cfg_wdata_i;
          tlrf_pkg::REG_SECOND_TERM: second_term_q <= cfg_wdata_i;
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.line_done     = done_q;
  assign out_o.first_seen    = pend_q;
  assign out_o.line_length   = 8'(count_q);
  assign out_o.read_data     = rd_ok_q ? store_rdata : 8'd0;
  assign out_o.restart_cause = cause_q;

  // A held line always keeps its pending terminator flag.
  a_done_implies_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> pend_q)
    else $error("line held without pending terminator");

  // Only a read request may return store data.
  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.cmd != tlrf_pkg::CMD_READ)) |=> (out_o.read_data == 8'd0))
    else $error("store data returned for a non-read request");

  // An overflow restart leaves an empty line with nothing pending.
  a_overflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (cause_q == tlrf_pkg::CAUSE_OVERFLOW)) |->
      ((count_q == '0) && !pend_q && !done_q))
    else $error("overflow restart did not empty the line");

  // Status moves only when a request is accepted.
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(count_q) && $stable(done_q) && $stable(pend_q)))
    else $error("status changed without a request");

endmodule

// File: test/tlrf_status_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the framer's status results and compares them with the block.
module tlrf_status_checker #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_wdata_i,
  tlrf_req_if                          req_i,
  tlrf_rsp_if                          rsp_i,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o
);

  // One predicted status result.
  typedef struct packed {
    logic             line_done;
    logic             first_seen;
    logic [7:0]       line_length;
    logic [7:0]       read_data;
    tlrf_pkg::cause_e restart_cause;
  } line_status_t;

  line_status_t status_q[$];
  int unsigned  err_count = 0;

  // Model of the framer state and its terminator registers.
  logic [7:0]   first_term;
  logic [7:0]   second_term;
  logic         done_flag;
  logic         term_pending;
  int unsigned  byte_count;
  logic [7:0]   line_mem [BUFFER_DEPTH];

  // Applies one request to the model and returns the status that it reports.
  function automatic line_status_t advance_line(logic [1:0] cmd, logic [7:0] rx,
                                                logic [7:0] idx);
    line_status_t st;
    st.read_data     = '0;
    st.restart_cause = tlrf_pkg::CAUSE_NONE;
    case (cmd)
      tlrf_pkg::CMD_RX: begin
        if (done_flag) begin
          // A held line swallows further bytes.
        end else if (term_pending) begin
          if (rx != second_term) begin
            term_pending     = 1'b0;
            byte_count       = 0;
            st.restart_cause = tlrf_pkg::CAUSE_BAD_SECOND;
          end else begin
            done_flag = 1'b1;
          end
        end else if (rx == first_term) begin
          term_pending = 1'b1;
        end else begin
          if (byte_count < BUFFER_DEPTH) line_mem[byte_count] = rx;
          byte_count++;
          if (byte_count >= BUFFER_DEPTH) begin
            byte_count       = 0;
            st.restart_cause = tlrf_pkg::CAUSE_OVERFLOW;
          end
        end
      end
      tlrf_pkg::CMD_READ: begin
        if (idx < BUFFER_DEPTH) st.read_data = line_mem[idx];
      end
      tlrf_pkg::CMD_RELEASE: begin
        done_flag    = 1'b0;
        term_pending = 1'b0;
        byte_count   = 0;
      end
      default: ;
    endcase
    st.line_done   = done_flag;
    st.first_seen  = term_pending;
    st.line_length = 8'(byte_count);
    return st;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_status_t want;
    if (!rst_ni) begin
      first_term   = tlrf_pkg::FIRST_TERM_RST;
      second_term  = tlrf_pkg::SECOND_TERM_RST;
      done_flag    = 1'b0;
      term_pending = 1'b0;
      byte_count   = 0;
      for (int i = 0; i < BUFFER_DEPTH; i++) line_mem[i] = '0;
      status_q.delete();
    end else begin
      // Compare each result taken by the receiver with the oldest prediction.
      if (rsp_i.valid && rsp_i.ready) begin
        if (status_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          err_count++;
        end else begin
          want = status_q.pop_front();
          check_field("line_done", want.line_done, rsp_i.line_done);
          check_field("first_seen", want.first_seen, rsp_i.first_seen);
          check_field("line_length", want.line_length, rsp_i.line_length);
          check_field("read_data", want.read_data, rsp_i.read_data);
          check_field("restart_cause", want.restart_cause, rsp_i.restart_cause);
        end
      end

      // Terminator writes; spare indexes are ignored.
      if (cfg_we_i) begin
        case (cfg_index_i)
          tlrf_pkg::REG_FIRST_TERM:  first_term = cfg_wdata_i;
          tlrf_pkg::REG_SECOND_TERM: second_term = cfg_wdata_i;
          default: ;
        endcase
      end

      // Predict the result of each accepted request.
      if (req_i.valid && req_i.ready) begin
        status_q.push_back(advance_line(req_i.cmd, req_i.rx_byte, req_i.read_index));
      end
    end
    errors_o  <= err_count;
    pending_o <= status_q.size();
  end

endmodule

// File: test/terminated_line_receive_framer_tb.sv
`timescale 1ns / 100ps
// Testbench top of the terminated line receive framer: clock, reset, requests and verdict.
module terminated_line_receive_framer_tb;

  localparam int unsigned BatchCount    = 6;
  localparam int unsigned BatchRequests = 238;
  localparam int unsigned CycleLimit    = 200000;

  // Codes the package leaves unnamed.
  localparam logic [1:0]                   CMD_SPARE    = 2'd3;
  localparam logic [tlrf_pkg::CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [tlrf_pkg::CfgIdxW-1:0] REG_SPARE_HI = 2'd3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tlrf_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [7:0]                   cfg_wdata_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic [7:0]  first_t;
  logic [7:0]  second_t;

  tlrf_req_if req_ch ();
  tlrf_rsp_if rsp_ch ();

  terminated_line_receive_framer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_ch),
    .out_o       (rsp_ch)
  );

  tlrf_status_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Presents one request after random idle cycles and holds it until accepted.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] rx,
                              input logic [7:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.rx_byte    <= rx;
    req_ch.read_index <= idx;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  task automatic rx_req(input logic [7:0] b);
    send_request(tlrf_pkg::CMD_RX, b, 8'($urandom));
  endtask

  task automatic read_req(input logic [7:0] idx);
    send_request(tlrf_pkg::CMD_READ, 8'($urandom), idx);
  endtask

  task automatic release_req();
    send_request(tlrf_pkg::CMD_RELEASE, 8'($urandom), 8'($urandom));
  endtask

  // Stops requesting and waits until every result has been taken.
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tlrf_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      tlrf_pkg::REG_FIRST_TERM:  first_t = data;
      tlrf_pkg::REG_SECOND_TERM: second_t = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A line of payload, usually a proper terminator pair, a few reads and a release.
  task automatic line_round(input int unsigned len);
    int unsigned pick;
    int unsigned top_idx;
    logic [7:0]  b;
    repeat (len) begin
      b = 8'($urandom);
      if (b == first_t) b = ~b;
      rx_req(b);
    end
    pick = $urandom_range(99);
    if (pick < 80) begin
      rx_req(first_t);
      rx_req(second_t);
    end else if (pick < 92) begin
      b = 8'($urandom);
      if (b == second_t) b = ~b;
      rx_req(first_t);
      rx_req(b);
    end
    // Late bytes are dropped while a line is held.
    repeat ($urandom_range(0, 2)) rx_req(8'($urandom));
    top_idx = (len + 1 > 255) ? 255 : len + 1;
    repeat ($urandom_range(1, 4)) begin
      read_req(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(top_idx)));
    end
    if ($urandom_range(9) != 0) release_req();
  endtask

  task automatic random_round();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // Arbitrary requests, the unused command among them.
      repeat ($urandom_range(1, 4)) send_request(2'($urandom_range(3)), 8'($urandom),
                                                 8'($urandom));
    end else if (pick < 12) begin
      line_round($urandom_range(250, 262));
    end else begin
      line_round($urandom_range(0, 12));
    end
  endtask

  initial begin
    int unsigned batch_start;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = tlrf_pkg::REG_FIRST_TERM;
    cfg_wdata_i       = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = tlrf_pkg::CMD_RX;
    req_ch.rx_byte    = '0;
    req_ch.read_index = '0;
    first_t           = tlrf_pkg::FIRST_TERM_RST;
    second_t          = tlrf_pkg::SECOND_TERM_RST;
    send_idle_pct     = 28;
    recv_idle_pct     = 52;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests with the terminators left at their reset values.
    read_req(8'd0);
    read_req(8'hFF);
    send_request(CMD_SPARE, 8'hFF, 8'hFF);
    rx_req(8'h00);
    rx_req(8'hFF);
    rx_req(tlrf_pkg::SECOND_TERM_RST);  // stored as payload with no first terminator pending
    rx_req(tlrf_pkg::FIRST_TERM_RST);
    rx_req(tlrf_pkg::SECOND_TERM_RST);
    rx_req(8'h55);                      // ignored while the line is held
    read_req(8'd0);
    read_req(8'd2);
    read_req(8'd3);
    release_req();
    rx_req(8'h10);
    rx_req(tlrf_pkg::FIRST_TERM_RST);
    rx_req(tlrf_pkg::FIRST_TERM_RST);   // wrong second terminator drops the line
    rx_req(tlrf_pkg::FIRST_TERM_RST);
    release_req();                      // release while a terminator is pending
    rx_req(tlrf_pkg::FIRST_TERM_RST);
    rx_req(tlrf_pkg::SECOND_TERM_RST);
    release_req();
    read_req(8'd0);                     // store contents survive a release
    drain();

    // Random batches, each under its own terminator setting; the idle mode changes at batches 2 and 4.
    for (int b = 0; b < BatchCount; b++) begin
      if (b == 2) begin
        send_idle_pct = 52;
        recv_idle_pct = 28;
      end else if (b == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (b)
        0: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'h00);
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'hFF);
        end
        1: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'hFF);
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'h00);
        end
        2: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'h41);
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'h41);
        end
        3: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'($urandom));
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'($urandom));
          write_reg(REG_SPARE_LO, 8'($urandom));
          write_reg(REG_SPARE_HI, 8'($urandom));
        end
        4: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'($urandom));
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'($urandom));
        end
        default: begin
          write_reg(tlrf_pkg::REG_FIRST_TERM, 8'h00);
          write_reg(tlrf_pkg::REG_SECOND_TERM, 8'h00);
        end
      endcase
      batch_start = sent;
      // The last batch always runs a line long enough to overflow the store.
      if (b == BatchCount - 1) line_round(258);
      while (sent - batch_start < BatchRequests) random_round();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
